### hw/rtl/ealu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ealu_pkg
// Shared types and constants of the eight-bit ALU: operation codes, the
// decoded work item passed from front to back, and the flag word.
// ----------------------------------------------------------------------------
package ealu_pkg;

	localparam int unsigned KIND_W  = 5;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned BIDX_W  = 3;

	localparam logic [3:0] LO_NIBBLE = 4'h0F;
	localparam logic [7:0] HI_NIBBLE = 8'hF0;
	localparam logic [7:0] SIGN_BIT  = 8'h80;

	// Operation codes as they arrive on the input channel; OP_NOP is internal
	typedef enum logic [KIND_W-1:0] {
		OP_ADD   = 5'd0,
		OP_ADC   = 5'd1,
		OP_SUB   = 5'd2,
		OP_SBC   = 5'd3,
		OP_AND   = 5'd4,
		OP_OR    = 5'd5,
		OP_XOR   = 5'd6,
		OP_CP    = 5'd7,
		OP_INC   = 5'd8,
		OP_DEC   = 5'd9,
		OP_ADDHL = 5'd10,
		OP_SET   = 5'd11,
		OP_RES   = 5'd12,
		OP_BIT   = 5'd13,
		OP_SWAP  = 5'd14,
		OP_SRL   = 5'd15,
		OP_SLA   = 5'd16,
		OP_SRA   = 5'd17,
		OP_RL    = 5'd18,
		OP_RR    = 5'd19,
		OP_RLC   = 5'd20,
		OP_RRC   = 5'd21,
		OP_NOP   = 5'd22
	} op_t;

	// Decoded item held in the queue between front and back
	typedef struct packed {
		op_t               op;
		logic [BYTE_W-1:0] acc;
		logic [BYTE_W-1:0] operand;
		logic [BYTE_W-1:0] mask;
		logic [WORD_W-1:0] hl;
		logic [WORD_W-1:0] wide;
	} item_t;

	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

	// Queue to back-end status
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

endpackage : ealu_pkg
`default_nettype wire

### hw/rtl/ealu_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ealu_if
// Valid/ready channels of the ALU: operation requests in, results out.
// ----------------------------------------------------------------------------
interface ealu_req_if;
	logic        valid;
	logic        ready;
	logic [4:0]  kind;
	logic [7:0]  acc_in;
	logic [7:0]  operand;
	logic [2:0]  bit_index;
	logic [15:0] hl_in;
	logic [15:0] wide_operand;

	modport source (output valid, kind, acc_in, operand, bit_index, hl_in, wide_operand,
		input ready);
	modport sink (input valid, kind, acc_in, operand, bit_index, hl_in, wide_operand,
		output ready);
endinterface : ealu_req_if

interface ealu_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  value_out;
	logic        write_back;
	logic [15:0] hl_out;
	logic        flag_zero;
	logic        flag_subtract;
	logic        flag_half;
	logic        flag_carry;

	modport source (output valid, value_out, write_back, hl_out, flag_zero, flag_subtract,
		flag_half, flag_carry, input ready);
	modport sink (input valid, value_out, write_back, hl_out, flag_zero, flag_subtract,
		flag_half, flag_carry, output ready);
endinterface : ealu_rsp_if
`default_nettype wire

### hw/rtl/eight_bit_alu_with_flags_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags_core
// Eight-bit ALU with Z/N/H/C flags: decode front, two-entry queue, execute
// back end with the flag register and a registered result.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  req     | in  | valid / ready | kind, acc_in, operand, bit_index, hl_in, wide_operand
//  rsp     | out | valid / ready | value_out, write_back, hl_out, flag_zero..flag_carry
//
//  One beat per cycle sustained while rsp is ready; an accepted beat enters the
//  queue, executes on leaving it and is shown on rsp from the result register.
//  The flag register feeds back into the execute stage.
//  Reset clears the flags to zero and empties queue and result register.
//  A stalled rsp holds its beat; req keeps accepting until the queue is full.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_flags_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ealu_req_if.sink    req,
	ealu_rsp_if.source  rsp
);
	import ealu_pkg::*;

	item_t push_item;
	logic  push;
	logic  not_full;
	logic  pop;
	head_t head;

	ealu_front u_front (
		.req     (req),
		.q_ready (not_full),
		.q_item  (push_item),
		.q_push  (push)
	);

	ealu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.not_full  (not_full),
		.pop       (pop),
		.head      (head)
	);

	ealu_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule : eight_bit_alu_with_flags_core
`default_nettype wire

### hw/rtl/ealu_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ealu_front
// Front end: classify the request beat into an internal operation and
// prepare the bit mask for set, res and bit.
// ----------------------------------------------------------------------------
module ealu_front (
	ealu_req_if.sink          req,
	input  wire logic         q_ready,
	output ealu_pkg::item_t   q_item,
	output logic              q_push
);
	import ealu_pkg::*;

	op_t op;

	// Map unused codes to a no-op
	always_comb begin
		if (req.kind inside {[OP_ADD:OP_RRC]}) begin
			op = op_t'(req.kind);
		end else begin
			op = OP_NOP;
		end
	end

	// Build the queue entry
	always_comb begin
		q_item.op      = op;
		q_item.acc     = req.acc_in;
		q_item.operand = req.operand;
		q_item.mask    = BYTE_W'(1) << req.bit_index;
		q_item.hl      = req.hl_in;
		q_item.wide    = req.wide_operand;
	end

	assign req.ready = q_ready;
	assign q_push    = req.valid & q_ready;

endmodule : ealu_front
`default_nettype wire

### hw/rtl/ealu_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ealu_queue
// Two-entry queue between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
module ealu_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  ealu_pkg::item_t      push_item,
	output logic                 not_full,
	input  wire logic            pop,
	output ealu_pkg::head_t      head
);
	import ealu_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	// Store payload
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	assign not_full   = (count_q != 2'd2);
	assign head.valid = (count_q != 2'd0);
	assign head.item  = slot_q[rd_ptr_q];

endmodule : ealu_queue
`default_nettype wire

### hw/rtl/ealu_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ealu_back
// Back end: execute the head operation against the held flags, update the
// flags and load the result register.
// ----------------------------------------------------------------------------
module ealu_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  ealu_pkg::head_t   head,
	output logic              pop,
	ealu_rsp_if.source        rsp
);
	import ealu_pkg::*;

	item_t       it;
	flags_t      flags_q;
	flags_t      nf;
	logic        cin;
	logic        cx;
	logic [7:0]  v;
	logic [7:0]  res;
	logic        wb;
	logic [15:0] hlo;
	logic [8:0]  sum9;
	logic [8:0]  diff9;
	logic [4:0]  nadd;
	logic [4:0]  nsub;
	logic [16:0] sum17;
	logic [12:0] nadd13;

	logic        out_valid_q;
	logic [7:0]  value_q;
	logic        wb_q;
	logic [15:0] hl_q;
	flags_t      oflags_q;

	assign it  = head.item;
	assign v   = it.operand;
	assign cin = flags_q.c;
	assign cx  = ((it.op == OP_ADC) || (it.op == OP_SBC)) ? cin : 1'b0;

	// Adders for the arithmetic group; the byte adders are shared between ops
	assign sum9   = {1'b0, it.acc} + {1'b0, v} + {8'd0, cx};
	assign diff9  = {1'b0, it.acc} - {1'b0, v} - {8'd0, cx};
	assign nadd   = {1'b0, it.acc[3:0]} + {1'b0, v[3:0]} + {4'd0, cx};
	assign nsub   = {1'b0, it.acc[3:0]} - {1'b0, v[3:0]} - {4'd0, cx};
	assign sum17  = {1'b0, it.hl} + {1'b0, it.wide};
	assign nadd13 = {1'b0, it.hl[11:0]} + {1'b0, it.wide[11:0]};

	// Execute one operation
	always_comb begin
		nf  = flags_q;
		res = '0;
		wb  = 1'b1;
		hlo = it.hl;
		case (it.op)
			OP_ADD, OP_ADC: begin
				res = sum9[7:0];
				nf  = '{z: (res == '0), n: 1'b0, h: nadd[4], c: sum9[8]};
			end
			OP_SUB, OP_SBC: begin
				res = diff9[7:0];
				nf  = '{z: (res == '0), n: 1'b1, h: nsub[4], c: diff9[8]};
			end
			OP_CP: begin
				nf  = '{z: (diff9[7:0] == '0), n: 1'b1, h: nsub[4], c: diff9[8]};
				wb  = 1'b0;
			end
			OP_AND: begin
				res = it.acc & v;
				nf  = '{z: (res == '0), n: 1'b0, h: 1'b1, c: 1'b0};
			end
			OP_OR: begin
				res = it.acc | v;
				nf  = '{z: (res == '0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			OP_XOR: begin
				res = it.acc ^ v;
				nf  = '{z: (res == '0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			OP_INC: begin
				res = v + 8'd1;
				nf  = '{z: (res == '0), n: 1'b0, h: (v[3:0] == LO_NIBBLE), c: cin};
			end
			OP_DEC: begin
				res = v - 8'd1;
				nf  = '{z: (res == '0), n: 1'b1, h: (v[3:0] == 4'd0), c: cin};
			end
			OP_ADDHL: begin
				hlo = sum17[15:0];
				nf  = '{z: flags_q.z, n: 1'b0, h: nadd13[12], c: sum17[16]};
				wb  = 1'b0;
			end
			OP_SET: begin
				res = v | it.mask;
			end
			OP_RES: begin
				res = v & ~it.mask;
			end
			OP_BIT: begin
				nf  = '{z: ((v & it.mask) == '0), n: 1'b0, h: 1'b1, c: cin};
				wb  = 1'b0;
			end
			OP_SWAP: begin
				res = {v[3:0], v[7:4]};
				nf  = '{z: ((v & (HI_NIBBLE | 8'(LO_NIBBLE))) == '0), n: 1'b0, h: 1'b0,
					c: 1'b0};
			end
			OP_SRL: begin
				res = {1'b0, v[7:1]};
				nf  = '{z: (res == '0), n: 1'b0, h: 1'b0, c: v[0]};
			end
			OP_SLA: begin
				res = {v[6:0], 1'b0};
				nf  = '{z: (res == '0), n: 1'b0, h: 1'b0, c: ((v & SIGN_BIT) != '0)};
			end
			OP_SRA: begin
				res = {v[7], v[7:1]};
				nf  = '{z: (res == '0), n: 1'b0, h: 1'b0, c: v[0]};
			end
			OP_RL: begin
				res = {v[6:0], cin};
				nf  = '{z: (res == '0), n: 1'b0, h: 1'b0, c: v[7]};
			end
			OP_RR: begin
				res = {cin, v[7:1]};
				nf  = '{z: (res == '0), n: 1'b0, h: 1'b0, c: v[0]};
			end
			OP_RLC: begin
				res = {v[6:0], v[7]};
				nf  = '{z: (res == '0), n: 1'b0, h: 1'b0, c: v[7]};
			end
			OP_RRC: begin
				res = {v[0], v[7:1]};
				nf  = '{z: (res == '0), n: 1'b0, h: 1'b0, c: v[0]};
			end
			default: begin
				wb  = 1'b0;
			end
		endcase
	end

	// Take the head when the result register is free or being drained
	assign pop = head.valid && (!out_valid_q || rsp.ready);

	// Flags and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				flags_q <= nf;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			value_q  <= res;
			wb_q     <= wb;
			hl_q     <= hlo;
			oflags_q <= nf;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.value_out     = value_q;
	assign rsp.write_back    = wb_q;
	assign rsp.hl_out        = hl_q;
	assign rsp.flag_zero     = oflags_q.z;
	assign rsp.flag_subtract = oflags_q.n;
	assign rsp.flag_half     = oflags_q.h;
	assign rsp.flag_carry    = oflags_q.c;

endmodule : ealu_back
`default_nettype wire

### hw/rtl/ealu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ealu_checker
// Port-level checks of the ALU core, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ealu_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [7:0]  rsp_value,
	input wire logic        rsp_wb,
	input wire logic [15:0] rsp_hl,
	input wire logic [3:0]  rsp_flags
);

	// Hold a stalled result beat
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_wb)
			&& $stable(rsp_hl) && $stable(rsp_flags))
		else $error("result beat changed while stalled");

	// Drop the result once reset has been seen at an edge
	a_rsp_reset: assert property (@(posedge clk) !arst_n |=> !rsp_valid)
		else $error("result valid after reset");

	// A full queue only happens behind a stalled result
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid)
		else $error("request refused with no pending result");

	// Non-stored results carry a zero byte
	a_no_wb_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_wb |-> rsp_value == 8'd0)
		else $error("value on a result without write-back");

	// An accepted beat passes the queue, and rsp then shows a result
	a_req_known: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> ##1 rsp_valid)
		else $error("accepted beat produced no result");

endmodule : ealu_checker

bind eight_bit_alu_with_flags_core ealu_checker u_ealu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_value (rsp.value_out),
	.rsp_wb    (rsp.write_back),
	.rsp_hl    (rsp.hl_out),
	.rsp_flags ({rsp.flag_zero, rsp.flag_subtract, rsp.flag_half, rsp.flag_carry})
);
`default_nettype wire
